// File: hdl/image_source_reflection_tap_macros.svh
// ---------------------------------------------------------------------------
// image_source_reflection_tap_macros
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef IMAGE_SOURCE_REFLECTION_TAP_MACROS_SVH
`define IMAGE_SOURCE_REFLECTION_TAP_MACROS_SVH

// Same-cycle implication, disabled while rst_sig is high.
`define ISRT_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("isrt check failed");

// Next-cycle implication, disabled while rst_sig is high.
`define ISRT_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("isrt check failed");

`endif

// File: hdl/isrt_pkg.sv
// ---------------------------------------------------------------------------
// isrt_pkg
// Types and constants of the image-source reflection tap.
// ---------------------------------------------------------------------------
package isrt_pkg;

  localparam int AD_W    = 20;  // |image - listener| per axis in mm
  localparam int D2_W    = 42;  // squared distance in mm^2
  localparam int ROOT_W  = 21;  // distance in mm
  localparam int QUO_W   = 36;  // width of 10^6 * 2^16 / d2
  localparam int ORD_W   = 5;
  localparam int GAIN_W  = 24;
  localparam int DELAY_W = 17;
  localparam int REFL_W  = 17;
  localparam int SCALE_W = 16;
  localparam int POS_W   = 48;
  localparam int POW_STEPS = 24;  // largest order: three indices of magnitude 8

  localparam logic [QUO_W-1:0]   DIST_NUM  = 36'd65536000000;  // 1 m^2 in Q16 mm^2
  localparam logic [GAIN_W-1:0]  GAIN_MAX  = '1;
  localparam logic [DELAY_W-1:0] DELAY_MAX = '1;
  localparam logic [GAIN_W-1:0]  UNITY_Q16 = 24'd65536;

  localparam logic [REFL_W-1:0]  REFL_RESET  = 17'd62259;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd3924;

  typedef enum logic [2:0] {
    REG_ROOM     = 3'd0,
    REG_SOURCE   = 3'd1,
    REG_LISTENER = 3'd2,
    REG_REFL     = 3'd3,
    REG_SCALE    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [3:0] z_image;
    logic signed [3:0] y_image;
    logic signed [3:0] x_image;
  } image_req_t;

  typedef struct packed {
    logic [DELAY_W-1:0] delay_samples;
    logic [GAIN_W-1:0]  tap_gain;
    logic [ORD_W-1:0]   reflection_order;
    logic               usable_tap;
  } tap_req_t;

endpackage

// File: hdl/isrt_stream_if.sv
// ---------------------------------------------------------------------------
// isrt_stream_if
// Valid/ready channel carrying one request per accepted cycle.
// ---------------------------------------------------------------------------
interface isrt_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/isrt_front.sv
// ---------------------------------------------------------------------------
// isrt_front
// Index clamp, mirrored coordinates, per-axis squares and squared distance.
// Four register stages, all advancing on en.
// ---------------------------------------------------------------------------
module isrt_front #(
  parameter int MAX_REFS = 7
) (
  input  logic                          clk,
  input  logic                          en,
  input  isrt_pkg::image_req_t          req,
  input  logic [isrt_pkg::POS_W-1:0]    room,
  input  logic [isrt_pkg::POS_W-1:0]    source,
  input  logic [isrt_pkg::POS_W-1:0]    listener,
  output logic [isrt_pkg::D2_W-1:0]     d2,
  output logic [isrt_pkg::ORD_W-1:0]    order
);

  localparam logic signed [4:0] LIM = 5'(MAX_REFS);

  logic signed [4:0]             n_raw [3];
  logic signed [4:0]             n_s1  [3];
  logic [isrt_pkg::AD_W-1:0]     ad_s2 [3];
  logic [isrt_pkg::ORD_W-1:0]    ord_s2, ord_s3;
  logic [2*isrt_pkg::AD_W-1:0]   sq_s3 [3];
  logic signed [22:0]            diff  [3];
  logic [3:0]                    an    [3];

  assign n_raw[0] = 5'(req.x_image);
  assign n_raw[1] = 5'(req.y_image);
  assign n_raw[2] = 5'(req.z_image);

  // Per-axis mirrored coordinate minus listener
  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [22:0] r, s, l, c;
    assign r = $signed({7'd0, room[16*a +: 16]});
    assign s = $signed({7'd0, source[16*a +: 16]});
    assign l = $signed({7'd0, listener[16*a +: 16]});
    assign c = 23'(n_s1[a]) * r + (n_s1[a][0] ? (r - s) : s);
    assign diff[a] = c - l;
    assign an[a] = n_s1[a][4] ? 4'(-n_s1[a]) : 4'(n_s1[a]);
  end

  // Stage 1: clamped indices
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        if (n_raw[a] > LIM) n_s1[a] <= LIM;
        else if (n_raw[a] < -LIM) n_s1[a] <= -LIM;
        else n_s1[a] <= n_raw[a];
      end
    end
  end

  // Stage 2: absolute distances per axis and order
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++)
        ad_s2[a] <= diff[a][22] ? isrt_pkg::AD_W'(-diff[a]) : isrt_pkg::AD_W'(diff[a]);
      ord_s2 <= isrt_pkg::ORD_W'(an[0]) + isrt_pkg::ORD_W'(an[1]) + isrt_pkg::ORD_W'(an[2]);
    end
  end

  // Stage 3: squares
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) sq_s3[a] <= ad_s2[a] * ad_s2[a];
      ord_s3 <= ord_s2;
    end
  end

  // Stage 4: squared distance
  always_ff @(posedge clk) begin
    if (en) begin
      d2 <= isrt_pkg::D2_W'(sq_s3[0]) + isrt_pkg::D2_W'(sq_s3[1])
          + isrt_pkg::D2_W'(sq_s3[2]);
      order <= ord_s3;
    end
  end

endmodule

// File: hdl/isrt_sqrt.sv
// ---------------------------------------------------------------------------
// isrt_sqrt
// Integer square root, one result bit per register stage.
// ---------------------------------------------------------------------------
module isrt_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [isrt_pkg::D2_W-1:0]     d2,
  output logic [isrt_pkg::ROOT_W-1:0]   root
);

  localparam int N = isrt_pkg::ROOT_W;

  logic [isrt_pkg::D2_W-1:0] v   [N];
  logic [isrt_pkg::D2_W-1:0] res [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [isrt_pkg::D2_W-1:0] BIT = isrt_pkg::D2_W'(1) << (2 * (N - 1 - k));
    logic [isrt_pkg::D2_W-1:0] v_in, res_in, trial;
    if (k == 0) begin : g_first
      assign v_in   = d2;
      assign res_in = '0;
    end else begin : g_rest
      assign v_in   = v[k-1];
      assign res_in = res[k-1];
    end
    assign trial = res_in + BIT;

    // Try the bit, keep it when it fits
    always_ff @(posedge clk) begin
      if (en) begin
        if (v_in >= trial) begin
          v[k]   <= v_in - trial;
          res[k] <= (res_in >> 1) + BIT;
        end else begin
          v[k]   <= v_in;
          res[k] <= res_in >> 1;
        end
      end
    end
  end

  assign root = res[N-1][isrt_pkg::ROOT_W-1:0];

endmodule

// File: hdl/isrt_div.sv
// ---------------------------------------------------------------------------
// isrt_div
// Restoring divide of the 1 m^2 constant by d2, one quotient bit per stage.
// ---------------------------------------------------------------------------
module isrt_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [isrt_pkg::D2_W-1:0]     d2,
  output logic [isrt_pkg::QUO_W-1:0]    quo
);

  localparam int N = isrt_pkg::QUO_W;
  localparam int W = isrt_pkg::D2_W;

  logic [W-1:0] rem [N];
  logic [W-1:0] den [N];
  logic [N-1:0] q   [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [W-1:0] rem_in, den_in;
    logic [N-1:0] q_in;
    logic [W:0]   sh;
    logic         ge;
    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = d2;
      assign q_in   = '0;
    end else begin : g_rest
      assign rem_in = rem[k-1];
      assign den_in = den[k-1];
      assign q_in   = q[k-1];
    end
    assign sh = {rem_in, isrt_pkg::DIST_NUM[N-1-k]};
    assign ge = sh >= {1'b0, den_in};

    // Shift in the next numerator bit and subtract when it fits
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? W'(sh - {1'b0, den_in}) : W'(sh);
        den[k] <= den_in;
        q[k]   <= {q_in[N-2:0], ge};
      end
    end
  end

  assign quo = q[N-1];

endmodule

// File: hdl/isrt_pow.sv
// ---------------------------------------------------------------------------
// isrt_pow
// Reflectivity raised to the order, one saturating multiply per stage.
// ---------------------------------------------------------------------------
module isrt_pow (
  input  logic                          clk,
  input  logic                          en,
  input  logic [isrt_pkg::ORD_W-1:0]    order,
  input  logic [isrt_pkg::REFL_W-1:0]   refl,
  output logic [isrt_pkg::GAIN_W-1:0]   pw
);

  localparam int N = isrt_pkg::POW_STEPS;
  localparam int G = isrt_pkg::GAIN_W;

  logic [G-1:0]                  p   [N];
  logic [isrt_pkg::ORD_W-1:0]    ord [N];

  for (genvar t = 0; t < N; t++) begin : g_stage
    logic [G-1:0]                 p_in, p_sat;
    logic [isrt_pkg::ORD_W-1:0]   ord_in;
    logic [G+isrt_pkg::REFL_W-1:0] prod;
    if (t == 0) begin : g_first
      assign p_in   = isrt_pkg::UNITY_Q16;
      assign ord_in = order;
    end else begin : g_rest
      assign p_in   = p[t-1];
      assign ord_in = ord[t-1];
    end
    assign prod  = p_in * refl;
    assign p_sat = (prod[G+isrt_pkg::REFL_W-1:G+16] != '0) ? isrt_pkg::GAIN_MAX
                                                           : prod[G+15:16];

    // Multiply only while this step is below the order
    always_ff @(posedge clk) begin
      if (en) begin
        p[t]   <= (isrt_pkg::ORD_W'(t) < ord_in) ? p_sat : p_in;
        ord[t] <= ord_in;
      end
    end
  end

  assign pw = p[N-1];

endmodule

// File: hdl/image_source_reflection_tap.sv
// ---------------------------------------------------------------------------
// image_source_reflection_tap
// Delay and gain of one image-source reflection per request.
// ---------------------------------------------------------------------------
//  channel   dir   handshake          payload
//  image     in    valid/ready        x_image, y_image, z_image
//  tap       out   valid/ready        delay_samples, tap_gain, order, usable
//  apb       in    psel/penable       five config registers at 8*i
//
//  One request per cycle unless the output stalls; stages: 4 front, 36 divide,
//  multiply, output. The 36-stage quotient pipeline sets the latency.
//  Reset clears the valid bits; config registers take their reset values.
//  A stalled output freezes the whole pipeline; image.ready drops only then.
// ---------------------------------------------------------------------------
module image_source_reflection_tap #(
  parameter int MAX_REFS = 7
) (
  input  logic        clk,
  input  logic        rst,
  isrt_stream_if.sink   image,
  isrt_stream_if.source tap,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int FRONT = 4;
  localparam int SQ_PAD  = isrt_pkg::QUO_W - isrt_pkg::ROOT_W;
  localparam int POW_PAD = isrt_pkg::QUO_W - isrt_pkg::POW_STEPS;
  localparam int DEPTH = FRONT + isrt_pkg::QUO_W + 2;

  logic [isrt_pkg::POS_W-1:0]   room_size, source_position, listener_position;
  logic [isrt_pkg::REFL_W-1:0]  reflectivity;
  logic [isrt_pkg::SCALE_W-1:0] delay_scale;

  logic                          en;
  logic [DEPTH-1:0]              vpipe;
  logic [isrt_pkg::D2_W-1:0]     d2;
  logic [isrt_pkg::ORD_W-1:0]    order;
  logic [isrt_pkg::ROOT_W-1:0]   root;
  logic [isrt_pkg::QUO_W-1:0]    quo;
  logic [isrt_pkg::GAIN_W-1:0]   pw;

  logic [isrt_pkg::ROOT_W-1:0]   root_dly [SQ_PAD];
  logic [isrt_pkg::GAIN_W-1:0]   pw_dly   [POW_PAD];
  logic [isrt_pkg::ORD_W-1:0]    ord_dly  [isrt_pkg::QUO_W];
  logic                          zero_dly [isrt_pkg::QUO_W];

  logic [36:0]                   dprod;
  logic [43:0]                   gprod_hi;
  logic [39:0]                   gprod_lo;
  logic                          zero_m1;
  logic [isrt_pkg::ORD_W-1:0]    ord_m1;
  logic [44:0]                   gsum;
  logic [isrt_pkg::GAIN_W-1:0]   gain;
  isrt_pkg::tap_req_t            out_reg;

  // Config writes and reads
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      room_size         <= '0;
      source_position   <= '0;
      listener_position <= '0;
      reflectivity      <= isrt_pkg::REFL_RESET;
      delay_scale       <= isrt_pkg::SCALE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (isrt_pkg::reg_idx_t'(paddr[5:3]))
        isrt_pkg::REG_ROOM:     room_size         <= pwdata[isrt_pkg::POS_W-1:0];
        isrt_pkg::REG_SOURCE:   source_position   <= pwdata[isrt_pkg::POS_W-1:0];
        isrt_pkg::REG_LISTENER: listener_position <= pwdata[isrt_pkg::POS_W-1:0];
        isrt_pkg::REG_REFL:     reflectivity      <= pwdata[isrt_pkg::REFL_W-1:0];
        isrt_pkg::REG_SCALE:    delay_scale       <= pwdata[isrt_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (isrt_pkg::reg_idx_t'(paddr[5:3]))
      isrt_pkg::REG_ROOM:     prdata = 64'(room_size);
      isrt_pkg::REG_SOURCE:   prdata = 64'(source_position);
      isrt_pkg::REG_LISTENER: prdata = 64'(listener_position);
      isrt_pkg::REG_REFL:     prdata = 64'(reflectivity);
      isrt_pkg::REG_SCALE:    prdata = 64'(delay_scale);
      default:                prdata = '0;
    endcase
  end

  // Global advance: move unless a finished tap waits
  assign en          = !vpipe[DEPTH-1] || tap.ready;
  assign image.ready = en;

  always_ff @(posedge clk) begin
    if (rst) vpipe <= '0;
    else if (en) vpipe <= {vpipe[DEPTH-2:0], image.valid};
  end

  isrt_front #(.MAX_REFS(MAX_REFS)) u_front (
    .clk(clk), .en(en), .req(image.data),
    .room(room_size), .source(source_position), .listener(listener_position),
    .d2(d2), .order(order)
  );

  isrt_sqrt u_sqrt (.clk(clk), .en(en), .d2(d2), .root(root));
  isrt_div  u_div  (.clk(clk), .en(en), .d2(d2), .quo(quo));
  isrt_pow  u_pow  (.clk(clk), .en(en), .order(order), .refl(reflectivity), .pw(pw));

  // Align root, power and side data with the quotient
  always_ff @(posedge clk) begin
    if (en) begin
      root_dly[0] <= root;
      for (int i = 1; i < SQ_PAD; i++) root_dly[i] <= root_dly[i-1];
      pw_dly[0] <= pw;
      for (int i = 1; i < POW_PAD; i++) pw_dly[i] <= pw_dly[i-1];
      ord_dly[0]  <= order;
      zero_dly[0] <= (d2 == '0);
      for (int i = 1; i < isrt_pkg::QUO_W; i++) begin
        ord_dly[i]  <= ord_dly[i-1];
        zero_dly[i] <= zero_dly[i-1];
      end
    end
  end

  // Multiply stage: delay product and split gain product
  always_ff @(posedge clk) begin
    if (en) begin
      dprod    <= root_dly[SQ_PAD-1] * delay_scale;
      gprod_hi <= quo[35:16] * pw_dly[POW_PAD-1];
      gprod_lo <= quo[15:0] * pw_dly[POW_PAD-1];
      zero_m1  <= zero_dly[isrt_pkg::QUO_W-1];
      ord_m1   <= ord_dly[isrt_pkg::QUO_W-1];
    end
  end

  // Output stage: saturate and flag
  assign gsum = 45'(gprod_hi) + 45'(gprod_lo[39:16]);
  always_comb begin
    if (zero_m1) gain = isrt_pkg::UNITY_Q16;
    else if (gsum[44:24] != '0) gain = isrt_pkg::GAIN_MAX;
    else gain = gsum[23:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_reg.delay_samples    <= (dprod[36:33] != '0) ? isrt_pkg::DELAY_MAX
                                                       : dprod[32:16];
      out_reg.tap_gain         <= gain;
      out_reg.reflection_order <= ord_m1;
      out_reg.usable_tap       <= (gain != '0) && (gain < isrt_pkg::UNITY_Q16);
    end
  end

  assign tap.valid = vpipe[DEPTH-1];
  assign tap.data  = out_reg;

endmodule

// File: hdl/isrt_checker.sv
// ---------------------------------------------------------------------------
// isrt_checker
// Port-level checks of the reflection tap, bound to the top level.
// ---------------------------------------------------------------------------
`include "image_source_reflection_tap_macros.svh"

module isrt_checker (
  input logic               clk,
  input logic               rst,
  input logic               image_ready,
  input logic               tap_valid,
  input logic               tap_ready,
  input isrt_pkg::tap_req_t tap_data
);

  // A held tap keeps its payload
  `ISRT_ASSERT_NEXT(a_hold, clk, rst, tap_valid && !tap_ready, tap_valid && $stable(tap_data))

  // Input back-pressure only comes from a waiting tap
  `ISRT_ASSERT_NOW(a_ready, clk, rst, !image_ready, tap_valid && !tap_ready)

  // Usable flag agrees with the gain
  `ISRT_ASSERT_NOW(a_usable, clk, rst, tap_valid,
    tap_data.usable_tap == ((tap_data.tap_gain != '0) && (tap_data.tap_gain < 24'd65536)))

  // Nothing comes out right after reset
  `ISRT_ASSERT_NOW(a_reset, clk, 1'b0, $past(rst), !tap_valid)

endmodule

bind image_source_reflection_tap isrt_checker u_isrt_checker (
  .clk(clk),
  .rst(rst),
  .image_ready(image.ready),
  .tap_valid(tap.valid),
  .tap_ready(tap.ready),
  .tap_data(tap.data)
);

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Streams image-room index triples through the reflection tap and checks
// every delay, gain, order and usable flag against an in-bench predictor,
// across several register settings and handshake idling patterns.
// ---------------------------------------------------------------------------
module testbench;

  localparam int REF_LIMIT = 7;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 60;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [5:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;

  isrt_stream_if #(.T(isrt_pkg::image_req_t)) image_ch ();
  isrt_stream_if #(.T(isrt_pkg::tap_req_t))   tap_ch ();

  image_source_reflection_tap dut (
    .clk(clk), .rst(rst), .image(image_ch), .tap(tap_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow of the block's registers
  logic [isrt_pkg::POS_W-1:0]   room_q, source_q, listener_q;
  logic [isrt_pkg::REFL_W-1:0]  refl_q;
  logic [isrt_pkg::SCALE_W-1:0] scale_q;

  isrt_pkg::image_req_t image_backlog[$];
  isrt_pkg::tap_req_t   expected_taps[$];
  int send_idle_pct, recv_idle_pct;
  int mismatches = 0;
  int taps_seen = 0;
  int hold_at_tap = -1;
  int hold_left = 0;
  int quiet_cycles = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Delay and gain of one image source under the current registers
  function automatic isrt_pkg::tap_req_t reflection_tap(isrt_pkg::image_req_t img);
    isrt_pkg::tap_req_t t;
    longint n, an, r, s, l, c, diff;
    longint unsigned d2, ord, root_mm, dly, base, pw, gain;
    logic signed [3:0] idx[3];
    idx[0] = img.x_image;
    idx[1] = img.y_image;
    idx[2] = img.z_image;
    d2 = 0;
    ord = 0;
    for (int a = 0; a < 3; a++) begin
      n = idx[a];
      if (n > REF_LIMIT) n = REF_LIMIT;
      if (n < -REF_LIMIT) n = -REF_LIMIT;
      an = (n < 0) ? -n : n;
      r = room_q[16*a +: 16];
      s = source_q[16*a +: 16];
      l = listener_q[16*a +: 16];
      c = n * r + ((an % 2 == 1) ? (r - s) : s);
      diff = c - l;
      if (diff < 0) diff = -diff;
      d2 += diff * diff;
      ord += an;
    end
    root_mm = root_floor(d2);
    dly = (root_mm * scale_q) >> 16;
    if (dly > isrt_pkg::DELAY_MAX) dly = isrt_pkg::DELAY_MAX;
    if (d2 == 0) begin
      gain = isrt_pkg::UNITY_Q16;
    end else begin
      base = (64'd1000000 << 16) / d2;
      pw = isrt_pkg::UNITY_Q16;
      for (longint unsigned k = 0; k < ord; k++) begin
        pw = (pw * refl_q) >> 16;
        if (pw > isrt_pkg::GAIN_MAX) pw = isrt_pkg::GAIN_MAX;
      end
      gain = (base * pw) >> 16;
      if (gain > isrt_pkg::GAIN_MAX) gain = isrt_pkg::GAIN_MAX;
    end
    t.delay_samples = dly[isrt_pkg::DELAY_W-1:0];
    t.tap_gain = gain[isrt_pkg::GAIN_W-1:0];
    t.reflection_order = ord[isrt_pkg::ORD_W-1:0];
    t.usable_tap = (gain > 0) && (gain < isrt_pkg::UNITY_Q16);
    return t;
  endfunction

  // Driver: offers the backlog, predicts each accepted request
  always @(posedge clk) begin
    logic take;
    take = image_ch.valid && image_ch.ready;
    if (rst) begin
      image_ch.valid <= 1'b0;
    end else begin
      if (take) begin
        expected_taps.insert(expected_taps.size(), reflection_tap(image_ch.data));
        void'(image_backlog.pop_front());
      end
      if (!image_ch.valid || take) begin
        if (image_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          image_ch.valid <= 1'b1;
          image_ch.data <= image_backlog[0];
        end else begin
          image_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, long hold once, compare results
  always @(posedge clk) begin
    isrt_pkg::tap_req_t exp_tap;
    if (rst) begin
      tap_ch.ready <= 1'b0;
    end else begin
      if (tap_ch.valid && tap_ch.ready) begin
        taps_seen++;
        if (expected_taps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected tap: %p", tap_ch.data);
        end else begin
          exp_tap = expected_taps.pop_front();
          if (tap_ch.data.delay_samples !== exp_tap.delay_samples ||
              tap_ch.data.tap_gain !== exp_tap.tap_gain ||
              tap_ch.data.reflection_order !== exp_tap.reflection_order ||
              tap_ch.data.usable_tap !== exp_tap.usable_tap) begin
            mismatches++;
            if (mismatches <= 10)
              $display("tap mismatch: expected %p actual %p", exp_tap, tap_ch.data);
          end
        end
        if (taps_seen == hold_at_tap) hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        tap_ch.ready <= 1'b0;
      end else begin
        tap_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any handshake or register access
  always @(posedge clk) begin
    if (rst || (image_ch.valid && image_ch.ready) || (tap_ch.valid && tap_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic reg_write(isrt_pkg::reg_idx_t idx, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 6'(8 * int'(idx));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    unique case (idx)
      isrt_pkg::REG_ROOM:     room_q = value[isrt_pkg::POS_W-1:0];
      isrt_pkg::REG_SOURCE:   source_q = value[isrt_pkg::POS_W-1:0];
      isrt_pkg::REG_LISTENER: listener_q = value[isrt_pkg::POS_W-1:0];
      isrt_pkg::REG_REFL:     refl_q = value[isrt_pkg::REFL_W-1:0];
      isrt_pkg::REG_SCALE:    scale_q = value[isrt_pkg::SCALE_W-1:0];
      default: ;
    endcase
  endtask

  // wait until every expected tap has arrived and the pipe is empty
  task automatic drain();
    while (image_backlog.size() > 0 || image_ch.valid || expected_taps.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_image(int x, int y, int z);
    isrt_pkg::image_req_t img;
    img.x_image = 4'(x);
    img.y_image = 4'(y);
    img.z_image = 4'(z);
    image_backlog.insert(image_backlog.size(), img);
  endtask

  // mostly low orders, some anywhere in the 4-bit range
  task automatic push_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0)
        push_image($urandom_range(15), $urandom_range(15), $urandom_range(15));
      else
        push_image($urandom_range(4) - 2, $urandom_range(4) - 2, $urandom_range(4) - 2);
    end
  endtask

  function automatic logic [63:0] rand_pos();
    return {16'd0, 16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  // Stimulus
  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    room_q = '0;
    source_q = '0;
    listener_q = '0;
    refl_q = isrt_pkg::REFL_RESET;
    scale_q = isrt_pkg::SCALE_RESET;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset registers: zero distance everywhere
    push_image(0, 0, 0);
    push_image(7, -7, 8);
    drain();

    // typical room, directed extremes of the indices
    reg_write(isrt_pkg::REG_ROOM, {16'd3000, 16'd4000, 16'd5000});
    reg_write(isrt_pkg::REG_SOURCE, {16'd1200, 16'd1500, 16'd2000});
    reg_write(isrt_pkg::REG_LISTENER, {16'd1200, 16'd1500, 16'd2000});
    push_image(0, 0, 0);     // image on the listener
    push_image(1, 0, 0);
    push_image(-1, 0, 0);
    push_image(0, 1, -1);
    push_image(7, 7, 7);
    push_image(-7, -7, -7);
    push_image(8, 8, 8);     // -8 clamps to -7
    push_image(8, 0, 3);
    push_image(2, -3, 4);
    drain();

    // reflectivity zero, above one and one; zero and full delay scale
    reg_write(isrt_pkg::REG_REFL, 64'd0);
    push_image(0, 0, 0);
    push_image(1, 1, 0);
    drain();
    reg_write(isrt_pkg::REG_REFL, 64'h1FFFF);
    push_image(7, 7, 7);
    push_image(2, 0, 0);
    drain();
    reg_write(isrt_pkg::REG_REFL, 64'd65536);
    reg_write(isrt_pkg::REG_SCALE, 64'd0);
    push_image(3, 3, 3);
    drain();
    reg_write(isrt_pkg::REG_ROOM, 64'hFFFF_FFFF_FFFF);
    reg_write(isrt_pkg::REG_SOURCE, 64'hFFFF_FFFF_FFFF);
    reg_write(isrt_pkg::REG_LISTENER, 64'd0);
    reg_write(isrt_pkg::REG_SCALE, 64'hFFFF);
    push_image(7, 7, 7);     // long distance, delay saturates
    push_image(-7, -7, -7);
    push_image(0, 0, 0);
    push_image(1, 0, 0);
    drain();
    reg_write(isrt_pkg::REG_REFL, 64'd1);
    push_image(1, 1, 1);
    drain();

    // random phases over several settings and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(isrt_pkg::REG_ROOM, (ph == 5) ? 64'd0 : rand_pos());
      reg_write(isrt_pkg::REG_SOURCE, rand_pos());
      reg_write(isrt_pkg::REG_LISTENER, rand_pos());
      reg_write(isrt_pkg::REG_REFL,
                (ph == 0) ? 64'h1FFFF : 64'($urandom_range(65536, 1)));
      reg_write(isrt_pkg::REG_SCALE,
                (ph == 1) ? 64'hFFFF : 64'($urandom_range(65535, 1)));
      unique case (ph % 4)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 71; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 71; end
        default: begin send_idle_pct = 9; recv_idle_pct = 9; end
      endcase
      if (ph == 0) hold_at_tap = taps_seen + 40;  // pipe fills, input stalls
      push_random(90);
      drain();
      // sender pauses mid-setting until all results are in
      push_random(85);
      drain();
    end

    send_idle_pct = 0;
    recv_idle_pct = 0;
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+hdl
hdl/isrt_pkg.sv
hdl/isrt_stream_if.sv
hdl/isrt_front.sv
hdl/isrt_sqrt.sv
hdl/isrt_div.sv
hdl/isrt_pow.sv
hdl/image_source_reflection_tap.sv
hdl/isrt_checker.sv
verif/testbench.sv
